>>> rtl/gbs_pkg.sv
// shared types and constants for the greedy box suppression block
`timescale 1ns / 1ps

package gbs_pkg;

	localparam int MAX_KEPT  = 64;
	localparam int MAX_BOXES = 4096;

	localparam int KEPT_AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int KEPT_CW   = $clog2(MAX_KEPT + 1);
	localparam int BOX_CW    = $clog2(MAX_BOXES);

	localparam int COORD_W   = 16;
	localparam int SIZE_W    = 15;
	localparam int EDGE_W    = COORD_W + 1;
	localparam int DIFF_W    = EDGE_W + 1;
	localparam int AREA_W    = 2 * SIZE_W;
	localparam int UNION_W   = AREA_W + 1;
	localparam int THR_W     = 16;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = THR_W + UNION_W;
	localparam int INDEX_W   = 12;

	localparam logic [THR_W-1:0] THR_RESET = 16'd26214;

	// one stored box: origin and size, area is recomputed on read
	typedef struct packed {
		logic signed [COORD_W-1:0] left_pos;
		logic signed [COORD_W-1:0] top_pos;
		logic [SIZE_W-1:0]         width_v;
		logic [SIZE_W-1:0]         height_v;
	} box_t;

endpackage

>>> rtl/gbs_iou_cmp.sv
// pipelined overlap test of the new box against one stored box per cycle
`timescale 1ns / 1ps

module gbs_iou_cmp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  gbs_pkg::box_t                   kept_box,
	input  gbs_pkg::box_t                   new_box,
	input  logic [gbs_pkg::AREA_W-1:0]      new_area,
	input  logic [gbs_pkg::THR_W-1:0]       threshold,
	output logic                            out_valid,
	output logic                            suppress,
	output logic                            in_flight
);

	logic signed [gbs_pkg::EDGE_W-1:0] nx0, nx1, ny0, ny1;
	logic signed [gbs_pkg::EDGE_W-1:0] kx0, kx1, ky0, ky1;
	logic signed [gbs_pkg::EDGE_W-1:0] ix0, ix1, iy0, iy1;
	logic signed [gbs_pkg::DIFF_W-1:0] iw, ih;

	logic                              valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [gbs_pkg::SIZE_W-1:0]        iw_s2, ih_s2;
	logic [gbs_pkg::AREA_W-1:0]        ka_s2, ka_s3;
	logic [gbs_pkg::AREA_W-1:0]        inter_s3, inter_s4, inter_s5;
	logic [gbs_pkg::UNION_W-1:0]       uni_s4;
	logic [gbs_pkg::PROD_W-1:0]        prod_s5;
	logic                              sup_s6;

	always_comb begin
		nx0 = gbs_pkg::EDGE_W'(new_box.left_pos);
		ny0 = gbs_pkg::EDGE_W'(new_box.top_pos);
		nx1 = nx0 + $signed({2'b00, new_box.width_v});
		ny1 = ny0 + $signed({2'b00, new_box.height_v});
		kx0 = gbs_pkg::EDGE_W'(kept_box.left_pos);
		ky0 = gbs_pkg::EDGE_W'(kept_box.top_pos);
		kx1 = kx0 + $signed({2'b00, kept_box.width_v});
		ky1 = ky0 + $signed({2'b00, kept_box.height_v});
		ix0 = (nx0 > kx0) ? nx0 : kx0;
		iy0 = (ny0 > ky0) ? ny0 : ky0;
		ix1 = (nx1 < kx1) ? nx1 : kx1;
		iy1 = (ny1 < ky1) ? ny1 : ky1;
		iw  = gbs_pkg::DIFF_W'(ix1) - gbs_pkg::DIFF_W'(ix0);
		ih  = gbs_pkg::DIFF_W'(iy1) - gbs_pkg::DIFF_W'(iy0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// overlap extents never exceed the new box size when positive
	always_ff @(posedge clk) begin
		iw_s2    <= (iw > 0) ? iw[gbs_pkg::SIZE_W-1:0] : '0;
		ih_s2    <= (ih > 0) ? ih[gbs_pkg::SIZE_W-1:0] : '0;
		ka_s2    <= kept_box.width_v * kept_box.height_v;
		inter_s3 <= iw_s2 * ih_s2;
		ka_s3    <= ka_s2;
		uni_s4   <= {1'b0, new_area} + {1'b0, ka_s3} - {1'b0, inter_s3};
		inter_s4 <= inter_s3;
		prod_s5  <= threshold * uni_s4;
		inter_s5 <= inter_s4;
		sup_s6   <= {1'b0, inter_s5, gbs_pkg::FRAC_W'(0)} > prod_s5;
	end

	assign out_valid = valid_s6;
	assign suppress  = sup_s6;
	assign in_flight = valid_s2 | valid_s3 | valid_s4 | valid_s5 | valid_s6;

endmodule

>>> rtl/greedy_box_suppression.sv
// top level: greedy box suppression by intersection over union
`timescale 1ns / 1ps

//  channel   signals                                         direction  transfer
//  box in    start, busy, box_left/top/width/height,         in         start & !busy
//            last_in_frame
//  result    done, box_index, keep, table_full, frame_end    out        done (one cycle)
//  config    cfg_wr_en, cfg_wr_data                           in         cfg_wr_en
//
//  an item is compared with each of the N boxes stored so far in the frame (up to 64
//  with a full table); with an empty table the compare scan is skipped
//  the time an item takes is set by the single read port of the kept-box memory,
//  one stored box per cycle, plus the depth of the overlap compare pipeline
//  the result strobe rises the cycle busy falls; the receiver cannot stall
//  reset clears the stored-box count and the box index and sets the threshold to 0.4;
//  memory contents are not cleared, only entries below the count are read

module greedy_box_suppression (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [gbs_pkg::COORD_W-1:0] box_left,
	input  logic signed [gbs_pkg::COORD_W-1:0] box_top,
	input  logic [gbs_pkg::SIZE_W-1:0]       box_width,
	input  logic [gbs_pkg::SIZE_W-1:0]       box_height,
	input  logic                             last_in_frame,
	output logic                             done,
	output logic [gbs_pkg::INDEX_W-1:0]      box_index,
	output logic                             keep,
	output logic                             table_full,
	output logic                             frame_end,
	input  logic                             cfg_wr_en,
	input  logic [gbs_pkg::THR_W-1:0]        cfg_wr_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t                        state_q;
	logic [gbs_pkg::THR_W-1:0]     thr_q;
	logic [gbs_pkg::KEPT_CW-1:0]   kept_cnt_q;
	logic [gbs_pkg::KEPT_CW-1:0]   rd_cnt_q;
	logic [gbs_pkg::BOX_CW-1:0]    box_cnt_q;
	gbs_pkg::box_t                 nb_q;
	logic                          last_q;
	logic [gbs_pkg::AREA_W-1:0]    na_q;
	logic                          supp_q;

	logic                          done_q, keep_q, full_q, frame_end_q;
	logic [gbs_pkg::INDEX_W-1:0]   box_index_q;

	// kept-box table, one read and one write port
	gbs_pkg::box_t                 kept_mem [gbs_pkg::MAX_KEPT];
	gbs_pkg::box_t                 rd_data_s1;
	logic                          valid_s1;

	logic                          accept;
	logic                          issue;
	logic                          last_issue;
	logic                          finish;
	logic                          room;
	logic                          mem_we;
	logic                          cmp_valid, cmp_sup, cmp_busy;

	assign accept     = start && (state_q == ST_IDLE);
	assign issue      = (state_q == ST_SCAN);
	assign last_issue = issue && ((rd_cnt_q + gbs_pkg::KEPT_CW'(1)) == kept_cnt_q);
	// all compares have landed in the suppress flag
	assign finish     = (state_q == ST_DRAIN) && !valid_s1 && !cmp_busy;
	assign room       = (kept_cnt_q < gbs_pkg::KEPT_CW'(gbs_pkg::MAX_KEPT));
	assign mem_we     = finish && !supp_q && room;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			kept_mem[kept_cnt_q[gbs_pkg::KEPT_AW-1:0]] <= nb_q;
		end
		rd_data_s1 <= kept_mem[rd_cnt_q[gbs_pkg::KEPT_AW-1:0]];
	end

	// new box area, ready long before the union stage needs it
	always_ff @(posedge clk) begin
		na_q <= nb_q.width_v * nb_q.height_v;
		if (accept) begin
			nb_q.left_pos <= box_left;
			nb_q.top_pos  <= box_top;
			nb_q.width_v  <= box_width;
			nb_q.height_v <= box_height;
			last_q        <= last_in_frame;
		end
	end

	gbs_iou_cmp u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.kept_box  (rd_data_s1),
		.new_box   (nb_q),
		.new_area  (na_q),
		.threshold (thr_q),
		.out_valid (cmp_valid),
		.suppress  (cmp_sup),
		.in_flight (cmp_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= gbs_pkg::THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kept_cnt_q  <= '0;
			rd_cnt_q    <= '0;
			box_cnt_q   <= '0;
			supp_q      <= 1'b0;
			valid_s1    <= 1'b0;
			done_q      <= 1'b0;
			keep_q      <= 1'b0;
			full_q      <= 1'b0;
			frame_end_q <= 1'b0;
			box_index_q <= '0;
		end else begin
			// one-cycle result strobe
			done_q   <= finish;
			valid_s1 <= issue;
			if (cmp_valid && cmp_sup) begin
				supp_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						rd_cnt_q <= '0;
						supp_q   <= 1'b0;
						state_q  <= (kept_cnt_q == '0) ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_cnt_q <= rd_cnt_q + gbs_pkg::KEPT_CW'(1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						keep_q      <= !supp_q;
						full_q      <= !supp_q && !room;
						frame_end_q <= last_q;
						box_index_q <= gbs_pkg::INDEX_W'(box_cnt_q);
						if (last_q) begin
							kept_cnt_q <= '0;
							box_cnt_q  <= '0;
						end else begin
							if (mem_we) begin
								kept_cnt_q <= kept_cnt_q + gbs_pkg::KEPT_CW'(1);
							end
							if (box_cnt_q == gbs_pkg::BOX_CW'(gbs_pkg::MAX_BOXES - 1)) begin
								box_cnt_q <= '0;
							end else begin
								box_cnt_q <= box_cnt_q + gbs_pkg::BOX_CW'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign box_index  = box_index_q;
	assign keep       = keep_q;
	assign table_full = full_q;
	assign frame_end  = frame_end_q;

	// stored count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_cnt_q <= gbs_pkg::KEPT_CW'(gbs_pkg::MAX_KEPT))
		else $error("kept count exceeds table depth");

	// a table write never overlaps a read still in the compare pipeline
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (!valid_s1 && !cmp_busy))
		else $error("table write while compares in flight");

	// a full-table flag only comes with a kept box
	a_full_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_full) |-> keep)
		else $error("table_full without keep");

	// every result follows the drain state and releases the block
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(state_q == ST_DRAIN)))
		else $error("result outside of scan completion");

endmodule
